@@ hw/rtl/btree_leaf_pair_slot_engine_unit_defines.svh @@
// ---------------------------------------------------------------------------
// btree_leaf_pair_slot_engine_unit_defines
// Assertion macros used by the leaf pair slot engine unit.
// ---------------------------------------------------------------------------
`ifndef BTREE_LEAF_PAIR_SLOT_ENGINE_UNIT_DEFINES_SVH
`define BTREE_LEAF_PAIR_SLOT_ENGINE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BLP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/blpse_pkg.sv @@
// ---------------------------------------------------------------------------
// blpse_pkg
// Types, codes and constants of the leaf pair slot engine.
// ---------------------------------------------------------------------------
package blpse_pkg;

   localparam int SLOTS_DEFAULT = 8;

   typedef enum logic [2:0] {
      MODE_WRITE   = 3'd0,
      MODE_READ    = 3'd1,
      MODE_INSERT  = 3'd2,
      MODE_ERASE   = 3'd3,
      MODE_MV_BACK = 3'd4,
      MODE_MV_FRNT = 3'd5,
      MODE_BALANCE = 3'd6,
      MODE_NOP     = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_RANGE     = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   // Control phase of one word: decode, cross-node copy, source shift.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_COPY  = 2'd1,
      PH_SHIFT = 2'd2
   } phase_type;

   typedef struct packed {
      logic [31:0] key;
      logic [15:0] len;
      logic [63:0] hash;
   } entry_type;

   // Source selection of one slot cell for the next cycle.
   typedef enum logic [2:0] {
      SEL_HOLD  = 3'd0,
      SEL_NEW   = 3'd1,
      SEL_UP    = 3'd2, // take lower neighbor (shift toward higher slots)
      SEL_DOWN  = 3'd3, // take upper neighbor
      SEL_OTHER = 3'd4  // take a cell of the other node at an offset slot index
   } sel_type;

   typedef struct packed {
      sel_type    sel;
      logic [5:0] shift;  // distance for up or down shifts
   } cell_ctl_type;

endpackage

@@ hw/rtl/blpse_cell.sv @@
// ---------------------------------------------------------------------------
// blpse_cell
// One slot of a leaf node: holds a single entry and loads it from itself,
// a new entry, a neighbor value or a slot of the other node.
// ---------------------------------------------------------------------------
module blpse_cell (
   input  logic                clock,
   input  blpse_pkg::sel_type  sel,
   input  blpse_pkg::entry_type new_entry,
   input  blpse_pkg::entry_type up_entry,
   input  blpse_pkg::entry_type down_entry,
   input  blpse_pkg::entry_type other_entry,
   output blpse_pkg::entry_type entry
);

   blpse_pkg::entry_type entry_ff;
   blpse_pkg::entry_type entry_in;

   always_comb begin
      case (sel)
         blpse_pkg::SEL_NEW:   entry_in = new_entry;
         blpse_pkg::SEL_UP:    entry_in = up_entry;
         blpse_pkg::SEL_DOWN:  entry_in = down_entry;
         blpse_pkg::SEL_OTHER: entry_in = other_entry;
         default:              entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ hw/rtl/blpse_node.sv @@
// ---------------------------------------------------------------------------
// blpse_node
// A row of slot cells forming one leaf node. Each cell holds, takes the new
// entry, or picks a shifted slot of its own row or a slot of the other node.
// ---------------------------------------------------------------------------
module blpse_node #(
   parameter int SLOTS = blpse_pkg::SLOTS_DEFAULT,
   parameter int IW    = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  blpse_pkg::sel_type   sel,
   input  logic [IW:0]          lo,      // first slot affected
   input  logic [IW:0]          hi,      // one past last slot affected
   input  logic [IW:0]          shift,
   input  logic [IW:0]          new_slot,
   input  logic [IW:0]          other_base, // other slot = i - other_base (mod)
   input  logic                 other_add,  // 1: other slot = i + other_base
   input  blpse_pkg::entry_type new_entry,
   input  blpse_pkg::entry_type other_row [SLOTS],
   output blpse_pkg::entry_type row [SLOTS]
);

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      localparam logic [IW:0] GI = (IW+1)'(g);
      blpse_pkg::sel_type   cs;
      blpse_pkg::entry_type up_e, down_e, oth_e;
      logic [IW:0] src_up, src_dn, src_ot;

      always_comb begin
         src_up = GI - shift;
         src_dn = GI + shift;
         src_ot = other_add ? GI + other_base : GI - other_base;
         up_e   = row[src_up[IW-1:0]];
         down_e = (src_dn < (IW+1)'(SLOTS)) ? row[src_dn[IW-1:0]] : row[g];
         oth_e  = other_row[src_ot[IW-1:0]];
         cs     = blpse_pkg::SEL_HOLD;
         if (GI >= lo && GI < hi) begin
            cs = sel;
            if (sel == blpse_pkg::SEL_UP && GI == new_slot)
               cs = blpse_pkg::SEL_NEW;
         end else if (sel == blpse_pkg::SEL_NEW && GI == new_slot) begin
            cs = blpse_pkg::SEL_NEW;
         end
      end

      blpse_cell u_cell (
         .clock       (clock),
         .sel         (cs),
         .new_entry   (new_entry),
         .up_entry    (up_e),
         .down_entry  (down_e),
         .other_entry (oth_e),
         .entry       (row[g])
      );
   end

endmodule

@@ hw/rtl/btree_leaf_pair_slot_engine_unit.sv @@
// ---------------------------------------------------------------------------
// btree_leaf_pair_slot_engine_unit
// Two B+tree leaf nodes built from slot cells; write, read, insert, erase,
// moves between nodes and balance.
// ---------------------------------------------------------------------------
// A word is accepted while idle; the control then runs through the copy and
// shift phases, and the result strobe, which the receiver cannot stall, is
// shown in the shift phase. Busy is high in both, so no new word is taken
// before the result has been shown. Moves need both: the destination takes the
// moved slots in copy, and a front move shifts its source down in shift.
// Reset clears both fill counts and the control state; slot contents stay.
module btree_leaf_pair_slot_engine_unit #(
   parameter int SLOTS = blpse_pkg::SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_mode,
   input  logic         req_node_select,
   input  logic [3:0]   req_slot_index,
   input  logic [3:0]   req_move_count,
   input  logic [31:0]  req_entry_key,
   input  logic [15:0]  req_entry_key_length,
   input  logic [63:0]  req_entry_hash,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [31:0]  rsp_out_key,
   output logic [15:0]  rsp_out_key_length,
   output logic [63:0]  rsp_out_hash,
   output logic [3:0]   rsp_left_fill,
   output logic [3:0]   rsp_right_fill
);

   `include "btree_leaf_pair_slot_engine_unit_defines.svh"

   localparam int IW = $clog2(SLOTS);
   localparam int XW = (IW + 2 > 5) ? IW + 2 : 5;
   localparam logic [IW:0] NS = (IW+1)'(SLOTS);

   blpse_pkg::entry_type lrow [SLOTS];
   blpse_pkg::entry_type rrow [SLOTS];

   logic [IW:0] lcnt_ff, lcnt_in, rcnt_ff, rcnt_in;
   blpse_pkg::phase_type phase_ff, phase_in;
   blpse_pkg::status_type st_ff, st_in;
   logic        emit_ff, emit_in;      // entry is returned
   logic        enode_ff, enode_in;
   logic [IW:0] eslot_ff, eslot_in;
   logic        epre_ff, epre_in;      // entry comes from the old row (erase)
   blpse_pkg::entry_type pre_ff, pre_in;
   blpse_pkg::entry_type new_e;

   // Per-node controls.
   blpse_pkg::sel_type lsel, rsel;
   logic [IW:0] llo, lhi, lsh, lns, lob, rlo, rhi, rsh, rns, rob;
   logic        loa, roa;

   logic accept;
   assign accept = start && !busy;
   assign new_e  = '{key: req_entry_key, len: req_entry_key_length,
                     hash: req_entry_hash};

   // Decode of one word into cell controls, counts and result info.
   always_comb begin
      logic [IW:0]   sc, dc, idx, cnt, half;
      logic [XW-1:0] idx_x, cnt_x, sum_x;
      logic          s;
      lsel = blpse_pkg::SEL_HOLD; rsel = blpse_pkg::SEL_HOLD;
      llo = '0; lhi = '0; lsh = '0; lns = NS; lob = '0; loa = 1'b0;
      rlo = '0; rhi = '0; rsh = '0; rns = NS; rob = '0; roa = 1'b0;
      lcnt_in = lcnt_ff; rcnt_in = rcnt_ff;
      st_in = st_ff; emit_in = emit_ff; enode_in = enode_ff;
      eslot_in = eslot_ff; epre_in = epre_ff; pre_in = pre_ff;
      s     = req_node_select;
      sc    = s ? rcnt_ff : lcnt_ff;
      dc    = s ? lcnt_ff : rcnt_ff;
      idx_x = XW'(req_slot_index);
      cnt_x = XW'(req_move_count);
      idx   = (idx_x > XW'(SLOTS)) ? NS : (IW+1)'(idx_x);
      cnt   = (cnt_x > XW'(SLOTS)) ? NS : (IW+1)'(cnt_x);
      sum_x = cnt_x + XW'(dc);
      half  = (IW+1)'(({1'b0, lcnt_ff} + {1'b0, rcnt_ff}) >> 1);
      if (accept) begin
         st_in = blpse_pkg::ST_OK; emit_in = 1'b0; epre_in = 1'b0;
         enode_in = s; eslot_in = '0;
         case (blpse_pkg::mode_type'(req_mode))
            blpse_pkg::MODE_WRITE: begin
               if (idx_x >= XW'(SLOTS) || idx_x > XW'(sc)) st_in = blpse_pkg::ST_RANGE;
               else begin
                  if (s) begin rsel = blpse_pkg::SEL_NEW; rns = idx; end
                  else begin lsel = blpse_pkg::SEL_NEW; lns = idx; end
                  if (idx == sc) begin
                     if (s) rcnt_in = sc + 1'b1; else lcnt_in = sc + 1'b1;
                  end
                  emit_in = 1'b1; eslot_in = idx;
               end
            end
            blpse_pkg::MODE_READ: begin
               if (idx_x >= XW'(sc)) st_in = blpse_pkg::ST_RANGE;
               else begin emit_in = 1'b1; eslot_in = idx; end
            end
            blpse_pkg::MODE_INSERT: begin
               if (idx_x > XW'(sc)) st_in = blpse_pkg::ST_RANGE;
               else if (sc >= NS) st_in = blpse_pkg::ST_OVERFLOW;
               else begin
                  if (s) begin
                     rsel = blpse_pkg::SEL_UP; rlo = idx; rhi = sc + 1'b1;
                     rsh = (IW+1)'(1); rns = idx; rcnt_in = sc + 1'b1;
                  end else begin
                     lsel = blpse_pkg::SEL_UP; llo = idx; lhi = sc + 1'b1;
                     lsh = (IW+1)'(1); lns = idx; lcnt_in = sc + 1'b1;
                  end
                  emit_in = 1'b1; eslot_in = idx;
               end
            end
            blpse_pkg::MODE_ERASE: begin
               if (idx_x >= XW'(sc)) st_in = blpse_pkg::ST_RANGE;
               else begin
                  pre_in = s ? rrow[idx[IW-1:0]] : lrow[idx[IW-1:0]];
                  if (s) begin
                     rsel = blpse_pkg::SEL_DOWN; rlo = idx; rhi = sc - 1'b1;
                     rsh = (IW+1)'(1); rcnt_in = sc - 1'b1;
                  end else begin
                     lsel = blpse_pkg::SEL_DOWN; llo = idx; lhi = sc - 1'b1;
                     lsh = (IW+1)'(1); lcnt_in = sc - 1'b1;
                  end
                  emit_in = 1'b1; epre_in = 1'b1;
               end
            end
            blpse_pkg::MODE_MV_BACK, blpse_pkg::MODE_MV_FRNT: begin
               if (sum_x > XW'(SLOTS)) st_in = blpse_pkg::ST_OVERFLOW;
               else if (cnt_x > XW'(sc)) st_in = blpse_pkg::ST_UNDERFLOW;
               else begin
                  if (s) begin rcnt_in = sc - cnt; lcnt_in = dc + cnt; end
                  else begin lcnt_in = sc - cnt; rcnt_in = dc + cnt; end
                  emit_in = (sc != cnt);
                  // A front move shifts its source only after the result is
                  // shown, so the new last entry still sits at the old back.
                  if (req_mode == blpse_pkg::MODE_MV_FRNT) eslot_in = sc - 1'b1;
                  else eslot_in = sc - cnt - 1'b1;
                  // Back moves make room here; copy phase loads destination.
                  if (req_mode == blpse_pkg::MODE_MV_BACK) begin
                     if (s) begin
                        lsel = blpse_pkg::SEL_UP; llo = cnt; lhi = dc + cnt; lsh = cnt;
                     end else begin
                        rsel = blpse_pkg::SEL_UP; rlo = cnt; rhi = dc + cnt; rsh = cnt;
                     end
                  end
               end
            end
            blpse_pkg::MODE_BALANCE: begin
               enode_in = 1'b0;
               if (rcnt_ff < lcnt_ff) begin
                  rcnt_in = half; lcnt_in = lcnt_ff + rcnt_ff - half;
                  rsel = blpse_pkg::SEL_UP; rlo = half - rcnt_ff; rhi = half;
                  rsh = half - rcnt_ff;
               end else begin
                  lcnt_in = half; rcnt_in = lcnt_ff + rcnt_ff - half;
               end
               emit_in = (lcnt_in != '0); eslot_in = lcnt_in - 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Copy and shift phases of moves: copy across, then a front source shifts.
   logic [2:0]  mv_mode_ff;
   logic        mv_s_ff, mv_ok_ff;
   logic [IW:0] mv_sc_ff, mv_dc_ff, mv_cnt_ff;
   logic [2:0]  mv_mode_in;
   logic        mv_s_in, mv_ok_in;
   logic [IW:0] mv_sc_in, mv_dc_in, mv_cnt_in;
   blpse_pkg::sel_type l2sel, r2sel;
   logic [IW:0] l2lo, l2hi, l2sh, l2ob, r2lo, r2hi, r2sh, r2ob;
   logic        l2oa, r2oa;

   always_comb begin
      logic [IW:0] half;
      half = (IW+1)'(({1'b0, lcnt_ff} + {1'b0, rcnt_ff}) >> 1);
      mv_mode_in = req_mode; mv_s_in = req_node_select;
      mv_ok_in   = (st_in == blpse_pkg::ST_OK);
      mv_sc_in   = req_node_select ? rcnt_ff : lcnt_ff;
      mv_dc_in   = req_node_select ? lcnt_ff : rcnt_ff;
      mv_cnt_in  = (IW+1)'(req_move_count);
      if (req_mode == blpse_pkg::MODE_BALANCE) begin
         if (rcnt_ff < lcnt_ff) begin
            mv_mode_in = blpse_pkg::MODE_MV_BACK; mv_s_in = 1'b0;
            mv_sc_in = lcnt_ff; mv_dc_in = rcnt_ff; mv_cnt_in = half - rcnt_ff;
         end else begin
            mv_mode_in = blpse_pkg::MODE_MV_FRNT; mv_s_in = 1'b1;
            mv_sc_in = rcnt_ff; mv_dc_in = lcnt_ff; mv_cnt_in = half - lcnt_ff;
         end
      end
      if (!accept) begin
         mv_mode_in = mv_mode_ff; mv_s_in = mv_s_ff; mv_ok_in = mv_ok_ff;
         mv_sc_in = mv_sc_ff; mv_dc_in = mv_dc_ff; mv_cnt_in = mv_cnt_ff;
      end
   end

   always_comb begin
      logic mv;
      l2sel = blpse_pkg::SEL_HOLD; r2sel = blpse_pkg::SEL_HOLD;
      l2lo = '0; l2hi = '0; l2sh = '0; l2ob = '0; l2oa = 1'b0;
      r2lo = '0; r2hi = '0; r2sh = '0; r2ob = '0; r2oa = 1'b0;
      mv = mv_ok_ff && (mv_mode_ff == blpse_pkg::MODE_MV_BACK ||
                        mv_mode_ff == blpse_pkg::MODE_MV_FRNT);
      if (phase_ff == blpse_pkg::PH_COPY && mv) begin
         // Destination takes the moved slots from the source.
         if (mv_mode_ff == blpse_pkg::MODE_MV_BACK) begin
            if (mv_s_ff) begin
               l2sel = blpse_pkg::SEL_OTHER; l2lo = '0; l2hi = mv_cnt_ff;
               l2ob = mv_sc_ff - mv_cnt_ff; l2oa = 1'b1;
            end else begin
               r2sel = blpse_pkg::SEL_OTHER; r2lo = '0; r2hi = mv_cnt_ff;
               r2ob = mv_sc_ff - mv_cnt_ff; r2oa = 1'b1;
            end
         end else begin
            if (mv_s_ff) begin
               l2sel = blpse_pkg::SEL_OTHER; l2lo = mv_dc_ff;
               l2hi = mv_dc_ff + mv_cnt_ff; l2ob = mv_dc_ff;
            end else begin
               r2sel = blpse_pkg::SEL_OTHER; r2lo = mv_dc_ff;
               r2hi = mv_dc_ff + mv_cnt_ff; r2ob = mv_dc_ff;
            end
         end
      end else if (phase_ff == blpse_pkg::PH_SHIFT && mv &&
                   mv_mode_ff == blpse_pkg::MODE_MV_FRNT) begin
         if (mv_s_ff) begin
            r2sel = blpse_pkg::SEL_DOWN; r2lo = '0; r2hi = mv_sc_ff - mv_cnt_ff;
            r2sh = mv_cnt_ff;
         end else begin
            l2sel = blpse_pkg::SEL_DOWN; l2lo = '0; l2hi = mv_sc_ff - mv_cnt_ff;
            l2sh = mv_cnt_ff;
         end
      end
   end

   blpse_pkg::sel_type lsel_m, rsel_m;
   logic [IW:0] llo_m, lhi_m, lsh_m, rlo_m, rhi_m, rsh_m;
   always_comb begin
      if (accept) begin
         lsel_m = lsel; llo_m = llo; lhi_m = lhi; lsh_m = lsh;
         rsel_m = rsel; rlo_m = rlo; rhi_m = rhi; rsh_m = rsh;
      end else begin
         lsel_m = l2sel; llo_m = l2lo; lhi_m = l2hi; lsh_m = l2sh;
         rsel_m = r2sel; rlo_m = r2lo; rhi_m = r2hi; rsh_m = r2sh;
      end
   end

   blpse_node #(.SLOTS(SLOTS), .IW(IW)) u_left (
      .clock (clock), .sel (lsel_m), .lo (llo_m), .hi (lhi_m), .shift (lsh_m),
      .new_slot (accept ? lns : NS), .other_base (accept ? lob : l2ob),
      .other_add (accept ? loa : l2oa), .new_entry (new_e),
      .other_row (rrow), .row (lrow)
   );

   blpse_node #(.SLOTS(SLOTS), .IW(IW)) u_right (
      .clock (clock), .sel (rsel_m), .lo (rlo_m), .hi (rhi_m), .shift (rsh_m),
      .new_slot (accept ? rns : NS), .other_base (accept ? rob : r2ob),
      .other_add (accept ? roa : r2oa), .new_entry (new_e),
      .other_row (lrow), .row (rrow)
   );

   always_comb begin
      case (phase_ff)
         blpse_pkg::PH_IDLE: begin
            phase_in = accept ? blpse_pkg::PH_COPY : blpse_pkg::PH_IDLE;
         end
         blpse_pkg::PH_COPY: begin
            phase_in = blpse_pkg::PH_SHIFT;
         end
         default: begin
            phase_in = blpse_pkg::PH_IDLE;
         end
      endcase
   end

   always_comb begin
      busy      = phase_ff != blpse_pkg::PH_IDLE;
      rsp_valid = phase_ff == blpse_pkg::PH_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcnt_ff <= '0; rcnt_ff <= '0; phase_ff <= blpse_pkg::PH_IDLE; emit_ff <= 1'b0;
         mv_ok_ff <= 1'b0; mv_mode_ff <= blpse_pkg::MODE_NOP;
         st_ff <= blpse_pkg::ST_OK; epre_ff <= 1'b0;
      end else begin
         lcnt_ff <= lcnt_in; rcnt_ff <= rcnt_in; phase_ff <= phase_in;
         emit_ff <= emit_in; mv_ok_ff <= mv_ok_in; mv_mode_ff <= mv_mode_in;
         st_ff <= st_in; epre_ff <= epre_in;
      end
      enode_ff <= enode_in; eslot_ff <= eslot_in; pre_ff <= pre_in;
      mv_s_ff <= mv_s_in; mv_sc_ff <= mv_sc_in; mv_dc_ff <= mv_dc_in;
      mv_cnt_ff <= mv_cnt_in;
   end

   // Result word, shown in the shift phase, before a front move shifts its source.
   blpse_pkg::entry_type ret;
   always_comb begin
      ret = enode_ff ? rrow[eslot_ff[IW-1:0]] : lrow[eslot_ff[IW-1:0]];
      if (epre_ff) ret = pre_ff;
      if (!emit_ff) ret = '0;
   end

   assign rsp_status         = st_ff;
   assign rsp_out_key        = ret.key;
   assign rsp_out_key_length = ret.len;
   assign rsp_out_hash       = ret.hash;
   assign rsp_left_fill      = 4'(lcnt_ff);
   assign rsp_right_fill     = 4'(rcnt_ff);

   logic rsp_err;
   assign rsp_err = rsp_valid && st_ff != blpse_pkg::ST_OK;

   `BLP_ASSERT(a_fill_bound, clock, reset, lcnt_ff <= NS && rcnt_ff <= NS, "fill above SLOTS")
   `BLP_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy, "busy not raised")
   `BLP_ASSERT_NEXT(a_rsp_once, clock, reset, rsp_valid, !rsp_valid, "double strobe")
   `BLP_ASSERT(a_err_zero, clock, reset, !(rsp_err && emit_ff), "entry on error")

endmodule
